[src/cbst_pkg.sv]
// Package with shared constants, controller states and command/status types.
`timescale 1ns / 1ps

package cbst_pkg;

    localparam int KEY_W         = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WAIT,
        S_PLACE,
        S_T_INIT,
        S_T_LEFT,
        S_T_WRITE,
        S_T_UP,
        S_E_RD,
        S_E_LOAD
    } t_state;

    typedef struct packed {
        logic load;
        logic set_ovf;
        logic ins_shift;
        logic ins_place;
        logic trav_sel;
        logic trav_init;
        logic go_left;
        logic go_right;
        logic go_up;
        logic lvl_write;
        logic emit_init;
        logic emit_load;
        logic emit_next;
        logic clear_set;
    } t_cmd;

    typedef struct packed {
        logic pos_zero;
        logic key_less;
        logic full;
        logic last;
        logic left_ok;
        logic right_ok;
        logic is_right;
        logic at_root;
        logic final_k;
        logic out_free;
    } t_status;

endpackage

[src/cbst_if.sv]
// Valid/ready stream interfaces for the key input and the tree output.
`timescale 1ns / 1ps

interface cbst_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       value;
    logic                     last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink (input valid, input value, input last_item, output ready);
endinterface

interface cbst_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       key_out;
    logic                     final_out;
    logic                     overflowed;

    modport source (output valid, output key_out, output final_out, output overflowed,
                    input ready);
    modport sink (input valid, input key_out, input final_out, input overflowed,
                  output ready);
endinterface

[src/cbst_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cbst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/cbst_ctrl.sv]
// Controller state machine for loading, tree layout and level-order emission.
`timescale 1ns / 1ps

module cbst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    input  cbst_pkg::t_status i_status,
    output cbst_pkg::t_cmd  o_cmd
);
    import cbst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.full) begin
                        o_cmd.set_ovf = 1'b1;
                        n_state = i_in_last ? S_T_INIT : S_IDLE;
                    end else begin
                        n_state = S_INS_CHK;
                    end
                end
            end
            S_INS_CHK: begin
                n_state = i_status.pos_zero ? S_PLACE : S_INS_WAIT;
            end
            S_INS_WAIT: begin
                if (i_status.key_less) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state = S_INS_CHK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.ins_place = 1'b1;
                n_state = i_status.last ? S_T_INIT : S_IDLE;
            end
            S_T_INIT: begin
                o_cmd.trav_init = 1'b1;
                n_state = S_T_LEFT;
            end
            S_T_LEFT: begin
                o_cmd.trav_sel = 1'b1;
                if (i_status.left_ok) begin
                    o_cmd.go_left = 1'b1;
                end else begin
                    n_state = S_T_WRITE;
                end
            end
            S_T_WRITE: begin
                o_cmd.trav_sel  = 1'b1;
                o_cmd.lvl_write = 1'b1;
                if (i_status.right_ok) begin
                    o_cmd.go_right = 1'b1;
                    n_state = S_T_LEFT;
                end else begin
                    n_state = S_T_UP;
                end
            end
            S_T_UP: begin
                o_cmd.trav_sel = 1'b1;
                if (i_status.at_root) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_E_RD;
                end else if (i_status.is_right) begin
                    o_cmd.go_up = 1'b1;
                end else begin
                    o_cmd.go_up = 1'b1;
                    n_state = S_T_WRITE;
                end
            end
            S_E_RD: begin
                n_state = S_E_LOAD;
            end
            S_E_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_status.final_k) begin
                        o_cmd.clear_set = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[src/cbst_dp.sv]
// Datapath with the sorted key store, the level-order store and the output register.
`timescale 1ns / 1ps

module cbst_dp #(
    parameter int MAX_ITEMS = cbst_pkg::MAX_ITEMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [cbst_pkg::KEY_W-1:0] i_value,
    input  logic                          i_last,
    input  cbst_pkg::t_cmd                i_cmd,
    output cbst_pkg::t_status             o_status,
    cbst_out_if.source                    o_out
);
    import cbst_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [KEY_W-1:0] r_value;
    logic                    r_last;
    logic [CW-1:0]           r_count;
    logic                    r_ovf;
    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_node;
    logic [CW-1:0]           r_rank;
    logic [AW-1:0]           r_k;
    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_final;
    logic                    r_ovf_out;

    logic [CW:0]             w_left;
    logic [CW:0]             w_right;
    logic                    w_st_we;
    logic [AW-1:0]           w_st_raddr;
    logic [KEY_W-1:0]        w_st_wdata;
    logic [KEY_W-1:0]        w_st_rdata;
    logic [KEY_W-1:0]        w_lv_rdata;
    logic [CW-1:0]           w_node_dec;

    assign w_left     = {r_node, 1'b0};
    assign w_right    = {r_node, 1'b1};
    assign w_node_dec = r_node - CW'(1);
    assign w_st_we    = i_cmd.ins_shift | i_cmd.ins_place;
    assign w_st_wdata = i_cmd.ins_shift ? w_st_rdata : r_value;
    assign w_st_raddr = i_cmd.trav_sel ? r_rank[AW-1:0] : (r_pos - AW'(1));

    cbst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (r_pos),
        .i_wdata (w_st_wdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    cbst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS), .AW(AW)) u_level (
        .i_clk   (i_clk),
        .i_we    (i_cmd.lvl_write),
        .i_waddr (w_node_dec[AW-1:0]),
        .i_wdata (w_st_rdata),
        .i_raddr (r_k),
        .o_rdata (w_lv_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.ins_place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit_load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_last  <= i_last;
            r_pos   <= r_count[AW-1:0];
        end else if (i_cmd.ins_shift) begin
            r_pos <= r_pos - AW'(1);
        end
        if (i_cmd.trav_init) begin
            r_node <= CW'(1);
            r_rank <= '0;
        end else begin
            if (i_cmd.go_left) begin
                r_node <= w_left[CW-1:0];
            end else if (i_cmd.go_right) begin
                r_node <= w_right[CW-1:0];
            end else if (i_cmd.go_up) begin
                r_node <= r_node >> 1;
            end
            if (i_cmd.lvl_write) begin
                r_rank <= r_rank + CW'(1);
            end
        end
        if (i_cmd.emit_init) begin
            r_k <= '0;
        end else if (i_cmd.emit_next) begin
            r_k <= r_k + AW'(1);
        end
        if (i_cmd.emit_load) begin
            r_key     <= w_lv_rdata;
            r_final   <= o_status.final_k;
            r_ovf_out <= r_ovf;
        end
    end

    always_comb begin
        o_status.pos_zero = (r_pos == '0);
        o_status.key_less = (r_value < $signed(w_st_rdata));
        o_status.full     = (r_count == CW'(MAX_ITEMS));
        o_status.last     = r_last;
        o_status.left_ok  = (w_left <= {1'b0, r_count});
        o_status.right_ok = (w_right <= {1'b0, r_count});
        o_status.is_right = r_node[0] && (r_node != CW'(1));
        o_status.at_root  = (r_node == CW'(1));
        o_status.final_k  = (CW'(r_k) == (r_count - CW'(1)));
        o_status.out_free = !r_valid || o_out.ready;
    end

    assign o_out.valid      = r_valid;
    assign o_out.key_out    = r_key;
    assign o_out.final_out  = r_final;
    assign o_out.overflowed = r_ovf_out;
endmodule

[src/complete_bst_level_order.sv]
// Top level: complete binary search tree builder with level-order output.
// Each key is compared with the held keys, shifting each larger one up,
// and is then written into its place; a key dropped by a full store only sets the overflow flag.
// A last key also starts the tree walk over the held keys and then the emission of the result words.
// Keys are taken one at a time; the walk and the shifting insertion hold off the next key.
// Reset clears the key count, the overflow flag, the controller and the output valid.
`timescale 1ns / 1ps

module complete_bst_level_order #(
    parameter int MAX_ITEMS = cbst_pkg::MAX_ITEMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbst_in_if.sink    i_in,
    cbst_out_if.source o_out
);
    import cbst_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    cbst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_item),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cbst_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_in.value),
        .i_last   (i_in.last_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_out    (o_out)
    );
endmodule

[dv/tb_complete_bst_level_order.sv]
// Testbench for the complete binary search tree block: directed and random key sets checked word by word.
`timescale 1ns / 1ps

module tb_complete_bst_level_order;

    import cbst_pkg::*;

    localparam int CAPACITY       = MAX_ITEMS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 500;
    localparam int PHASE_KEYS     = 55;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    last_item;
    } t_key_word;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    last_word;
        logic                    overflowed;
    } t_tree_node;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbst_in_if  key_if ();
    cbst_out_if tree_if ();

    complete_bst_level_order dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .o_out   (tree_if)
    );

    always #10 i_clk = ~i_clk;

    t_key_word               pending_keys[$];
    t_tree_node              expected_nodes[$];
    logic signed [KEY_W-1:0] sorted_keys[$];
    logic                    keys_dropped = 1'b0;
    logic                    key_taken = 1'b0;
    int                      keys_queued = 0;
    int                      keys_accepted = 0;
    int                      send_idle_pct = 0;
    int                      stall_pct = 0;
    int                      mismatch_count = 0;
    int                      quiet_cycles = 0;

    initial begin
        key_if.valid = 1'b0;
        key_if.value = '0;
        key_if.last_item = 1'b0;
        tree_if.ready = 1'b0;
    end

    // Sorted insertion of one key; a closing key lays the set out as a complete search tree.
    task automatic absorb_key(input logic signed [KEY_W-1:0] v, input logic last);
        int                      pos;
        int                      n;
        int                      rank;
        int                      node;
        int                      sp;
        int                      walk[CAPACITY];
        logic signed [KEY_W-1:0] level_keys[CAPACITY];
        t_tree_node              w;
        if (sorted_keys.size() < CAPACITY) begin
            pos = sorted_keys.size();
            while (pos > 0 && v < sorted_keys[pos-1]) pos--;
            sorted_keys.insert(pos, v);
        end else begin
            keys_dropped = 1'b1;
        end
        if (last) begin
            n = sorted_keys.size();
            rank = 0;
            sp = 0;
            node = 1;
            while (node <= n || sp > 0) begin
                if (node <= n) begin
                    walk[sp] = node;
                    sp++;
                    node = node * 2;
                end else begin
                    sp--;
                    node = walk[sp];
                    level_keys[node-1] = sorted_keys[rank];
                    rank++;
                    node = node * 2 + 1;
                end
            end
            for (int k = 0; k < n; k++) begin
                w.key = level_keys[k];
                w.last_word = (k == n - 1);
                w.overflowed = keys_dropped;
                expected_nodes.push_back(w);
            end
            sorted_keys.delete();
            keys_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        key_taken <= i_rst_n && key_if.valid && key_if.ready;
        if (i_rst_n && key_if.valid && key_if.ready) begin
            keys_accepted++;
            absorb_key(key_if.value, key_if.last_item);
        end
    end

    always @(negedge i_clk) begin : key_driver
        t_key_word word;
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
        end else if (!key_if.valid || key_taken) begin
            if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word = pending_keys.pop_front();
                key_if.valid <= 1'b1;
                key_if.value <= word.value;
                key_if.last_item <= word.last_item;
            end else begin
                key_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        tree_if.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : tree_monitor
        t_tree_node node;
        if (i_rst_n && tree_if.valid && tree_if.ready) begin
            if (expected_nodes.size() == 0) begin
                $error("key_out word with nothing expected: actual %0d", tree_if.key_out);
                mismatch_count++;
            end else begin
                node = expected_nodes.pop_front();
                if (tree_if.key_out !== node.key) begin
                    $error("key_out expected %0d actual %0d", node.key, tree_if.key_out);
                    mismatch_count++;
                end
                if (tree_if.final_out !== node.last_word) begin
                    $error("final_out expected %0b actual %0b", node.last_word,
                           tree_if.final_out);
                    mismatch_count++;
                end
                if (tree_if.overflowed !== node.overflowed) begin
                    $error("overflowed expected %0b actual %0b", node.overflowed,
                           tree_if.overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (key_if.valid && key_if.ready) || (tree_if.valid && tree_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_value();
        case ($urandom_range(3))
            0: pick_value = 32'sh8000_0000 + $urandom_range(3);
            1: pick_value = 32'sh7FFF_FFFF - $urandom_range(3);
            2: pick_value = $signed($urandom_range(8)) - 4;
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic queue_key(input logic signed [KEY_W-1:0] v, input logic last);
        t_key_word word;
        word.value = v;
        word.last_item = last;
        pending_keys.push_back(word);
        keys_queued++;
    endtask

    task automatic queue_random_set(input int size);
        for (int i = 0; i < size; i++) queue_key(pick_value(), i == size - 1);
    endtask

    task automatic drain();
        while (keys_accepted != keys_queued) @(negedge i_clk);
        while (expected_nodes.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int extra_set);
        int budget;
        int r;
        send_idle_pct = idle;
        stall_pct = stall;
        budget = 0;
        if (extra_set != 0) begin
            queue_random_set(extra_set);
            budget = extra_set;
        end
        while (budget < PHASE_KEYS + extra_set) begin
            r = $urandom_range(99);
            if (r < 60) r = $urandom_range(8, 1);
            else if (r < 90) r = $urandom_range(24, 9);
            else r = $urandom_range(40, 25);
            queue_random_set(r);
            budget += r;
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_key(32'sd0, 1'b1);
        queue_key(32'sh7FFF_FFFF, 1'b0);
        queue_key(32'sh8000_0000, 1'b0);
        queue_key(32'sd0, 1'b0);
        queue_key(-32'sd1, 1'b0);
        queue_key(32'sd1, 1'b1);
        queue_key(32'sd5, 1'b0);
        queue_key(32'sd5, 1'b0);
        queue_key(32'sd5, 1'b1);
        for (int i = 7; i > 0; i--) queue_key(i * 32'sd1000 - 32'sd3500, i == 1);
        for (int i = 0; i < 6; i++) queue_key(32'shAAAA_5555 + i, i == 5);
        drain();

        run_phase(0, 0, CAPACITY);
        run_phase(81, 0, 0);
        run_phase(0, 81, 0);
        run_phase(10, 10, CAPACITY + 1 + $urandom_range(3));

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_nodes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
